FILE: sv/gpim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpim_pkg
// Shared types and constants for the ground-plane inverse perspective map.
// ----------------------------------------------------------------------------
package gpim_pkg;

   localparam int COEF_W  = 48;   // Q23.24 homography coefficients
   localparam int PIX_W   = 11;   // bird's-eye-view pixel index
   localparam int COORD_W = 24;   // Q15.8 source coordinate
   localparam int PROD_W  = 60;   // coefficient times pixel index
   localparam int ACC_W   = 61;   // numerator / denominator sums
   localparam int QUO_W   = 25;   // 16 integer bits plus 9 fraction bits
   localparam int INT_W   = 16;   // integer quotient bits before saturation

   typedef enum logic [2:0] {
      CSR_U_COL   = 3'd0,
      CSR_U_ROW   = 3'd1,
      CSR_U_CONST = 3'd2,
      CSR_V_COL   = 3'd3,
      CSR_V_ROW   = 3'd4,
      CSR_V_CONST = 3'd5,
      CSR_W_COL   = 3'd6,
      CSR_W_ROW   = 3'd7
   } csr_index_type;

   localparam logic signed [COEF_W-1:0]  COEF_ONE  = 48'sd16777216;
   localparam logic signed [ACC_W-1:0]   DEN_ONE   = 61'sd16777216;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   typedef struct packed {
      logic [PIX_W-1:0] bev_col;
      logic [PIX_W-1:0] bev_row;
   } bev_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] src_u;
      logic signed [COORD_W-1:0] src_v;
      logic                      coord_invalid;
   } src_rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] u_col;
      logic signed [COEF_W-1:0] u_row;
      logic signed [COEF_W-1:0] u_const;
      logic signed [COEF_W-1:0] v_col;
      logic signed [COEF_W-1:0] v_row;
      logic signed [COEF_W-1:0] v_const;
      logic signed [COEF_W-1:0] w_col;
      logic signed [COEF_W-1:0] w_row;
   } coef_set_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] num_u;
      logic signed [ACC_W-1:0] num_v;
      logic signed [ACC_W-1:0] den;
      logic                    outside;
   } acc_set_type;

endpackage

FILE: sv/ground_plane_inverse_perspective_map.sv
`timescale 1ns / 1ps
// Pipeline: two multiply/sum stages, one sign and overflow stage, 25 divider
//   stages and one output register lie between req transfer and rsp valid.
// Throughput: one pixel per clock; each divider stage resolves one quotient
//   bit, and a stall only holds stages that have a full successor.
// Reset: clears all valid bits and loads the identity coefficients.
// ----------------------------------------------------------------------------
// ground_plane_inverse_perspective_map
// Maps a bird's-eye-view pixel to the Q15.8 source-camera coordinate through
// a programmable 3x3 homography with the last entry fixed at one.
// ----------------------------------------------------------------------------
module ground_plane_inverse_perspective_map #(
   parameter int BEV_DIM = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  gpim_pkg::bev_req_type   req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gpim_pkg::src_rsp_type   rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  gpim_pkg::csr_index_type csr_index,
   input  logic [47:0]             csr_wdata
);
   import gpim_pkg::*;

   coef_set_type coef;
   acc_set_type  acc;
   logic         acc_valid, acc_ready;

   // Coefficient registers
   gpim_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   // Numerators and denominator
   gpim_mac #(
      .BEV_DIM (BEV_DIM)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_data  (acc)
   );

   // Perspective divide and output formatting
   gpim_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (acc_ready),
      .in_data   (acc),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

FILE: sv/gpim_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpim_csr
// Homography coefficient registers, written through the csr channel.
// ----------------------------------------------------------------------------
module gpim_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  gpim_pkg::csr_index_type  csr_index,
   input  logic [47:0]              csr_wdata,
   output gpim_pkg::coef_set_type   coef
);
   import gpim_pkg::*;

   coef_set_type coef_ff, coef_in;

   // Always able to take a write
   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   // Update the addressed coefficient on a transfer
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_U_COL:   coef_in.u_col   = csr_wdata;
            CSR_U_ROW:   coef_in.u_row   = csr_wdata;
            CSR_U_CONST: coef_in.u_const = csr_wdata;
            CSR_V_COL:   coef_in.v_col   = csr_wdata;
            CSR_V_ROW:   coef_in.v_row   = csr_wdata;
            CSR_V_CONST: coef_in.v_const = csr_wdata;
            CSR_W_COL:   coef_in.w_col   = csr_wdata;
            CSR_W_ROW:   coef_in.w_row   = csr_wdata;
            default:     coef_in = coef_ff;
         endcase
      end
   end

   // Reset to the identity mapping
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{u_col: COEF_ONE, v_row: COEF_ONE, default: '0};
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

FILE: sv/gpim_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpim_mac
// Two-stage multiply and sum of the homography rows for one pixel.
// ----------------------------------------------------------------------------
module gpim_mac #(
   parameter int BEV_DIM = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gpim_pkg::coef_set_type coef,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  gpim_pkg::bev_req_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gpim_pkg::acc_set_type  out_data
);
   import gpim_pkg::*;

   localparam logic [12:0] DimLimit = 13'(BEV_DIM);

   logic                      en_a, en_b;
   logic                      v_a_ff, v_b_ff;
   logic signed [PIX_W:0]     col_s, row_s;
   logic signed [PROD_W-1:0]  p_uc_ff, p_ur_ff, p_vc_ff, p_vr_ff, p_wc_ff, p_wr_ff;
   logic signed [PROD_W-1:0]  p_uc_in, p_ur_in, p_vc_in, p_vr_in, p_wc_in, p_wr_in;
   logic signed [COEF_W-1:0]  k_u_ff, k_v_ff;
   logic                      outside_ff, outside_in;
   acc_set_type               acc_ff, acc_in;

   // Stage enables: a stage moves when empty or when its successor moves
   assign en_b      = !v_b_ff || out_ready;
   assign en_a      = !v_a_ff || en_b;
   assign in_ready  = en_a;
   assign out_valid = v_b_ff;
   assign out_data  = acc_ff;

   // Products of each coefficient with the pixel indices
   assign col_s      = {1'b0, in_data.bev_col};
   assign row_s      = {1'b0, in_data.bev_row};
   assign p_uc_in    = coef.u_col * col_s;
   assign p_ur_in    = coef.u_row * row_s;
   assign p_vc_in    = coef.v_col * col_s;
   assign p_vr_in    = coef.v_row * row_s;
   assign p_wc_in    = coef.w_col * col_s;
   assign p_wr_in    = coef.w_row * row_s;
   assign outside_in = ({2'b00, in_data.bev_col} >= DimLimit) ||
                       ({2'b00, in_data.bev_row} >= DimLimit);

   // Sum the products into numerators and denominator
   always_comb begin
      acc_in.num_u   = ACC_W'(p_uc_ff) + ACC_W'(p_ur_ff) + ACC_W'(k_u_ff);
      acc_in.num_v   = ACC_W'(p_vc_ff) + ACC_W'(p_vr_ff) + ACC_W'(k_v_ff);
      acc_in.den     = ACC_W'(p_wc_ff) + ACC_W'(p_wr_ff) + DEN_ONE;
      acc_in.outside = outside_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
      end else begin
         if (en_a) begin
            v_a_ff <= in_valid;
         end
         if (en_b) begin
            v_b_ff <= v_a_ff;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en_a) begin
         p_uc_ff    <= p_uc_in;
         p_ur_ff    <= p_ur_in;
         p_vc_ff    <= p_vc_in;
         p_vr_ff    <= p_vr_in;
         p_wc_ff    <= p_wc_in;
         p_wr_ff    <= p_wr_in;
         k_u_ff     <= coef.u_const;
         k_v_ff     <= coef.v_const;
         outside_ff <= outside_in;
      end
      if (en_b) begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: sv/gpim_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpim_div
// Pipelined restoring divider: one quotient bit per stage for both
// coordinates, then rounding, sign and saturation into the output register.
// ----------------------------------------------------------------------------
module gpim_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  gpim_pkg::acc_set_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output gpim_pkg::src_rsp_type out_data
);
   import gpim_pkg::*;

   localparam int NStep = QUO_W;

   typedef struct packed {
      logic [ACC_W-1:0] rem_u;
      logic [ACC_W-1:0] rem_v;
      logic [ACC_W-1:0] dvs;
      logic [INT_W-1:0] low_u;
      logic [INT_W-1:0] low_v;
      logic [QUO_W-1:0] q_u;
      logic [QUO_W-1:0] q_v;
      logic             neg_u;
      logic             neg_v;
      logic             ovf_u;
      logic             ovf_v;
      logic             dead;
   } div_state_type;

   function automatic logic [ACC_W-1:0] magnitude(input logic signed [ACC_W-1:0] x);
      magnitude = x[ACC_W-1] ? (~x + 1'b1) : x;
   endfunction

   // Round, apply sign and clamp; returns {saturated, coordinate}
   function automatic logic [COORD_W:0] finish(input logic [QUO_W-1:0] q,
                                               input logic neg,
                                               input logic ovf);
      logic [QUO_W-1:0] rnd;
      logic [QUO_W-1:0] neg_rnd;
      rnd     = QUO_W'(({1'b0, q} + 26'd1) >> 1);
      neg_rnd = ~rnd + 1'b1;
      if (ovf) begin
         finish = neg ? {1'b1, COORD_MIN} : {1'b1, COORD_MAX};
      end else if (neg) begin
         finish = (rnd > 25'd8388608) ? {1'b1, COORD_MIN} : {1'b0, neg_rnd[COORD_W-1:0]};
      end else begin
         finish = (rnd > 25'd8388607) ? {1'b1, COORD_MAX} : {1'b0, rnd[COORD_W-1:0]};
      end
   endfunction

   logic                       en [0:NStep+1];
   logic                       v_ff [0:NStep];
   div_state_type              st_ff [0:NStep];
   div_state_type              prep_in;
   logic [ACC_W-1:0]           un_u, un_v, ud;
   logic                       rsp_valid_ff;
   src_rsp_type                rsp_ff, rsp_in;
   logic [COORD_W:0]           fin_u, fin_v;

   // Enable chain, output register at the tail
   assign en[NStep+1] = !rsp_valid_ff || out_ready;
   for (genvar i = 0; i <= NStep; i++) begin : g_en
      assign en[i] = !v_ff[i] || en[i+1];
   end
   assign in_ready  = en[0];
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   // Prepare magnitudes, signs and the integer-part overflow test
   always_comb begin
      un_u            = magnitude(in_data.num_u);
      un_v            = magnitude(in_data.num_v);
      ud              = magnitude(in_data.den);
      prep_in.rem_u   = ACC_W'(un_u[ACC_W-1:INT_W]);
      prep_in.rem_v   = ACC_W'(un_v[ACC_W-1:INT_W]);
      prep_in.dvs     = ud;
      prep_in.low_u   = un_u[INT_W-1:0];
      prep_in.low_v   = un_v[INT_W-1:0];
      prep_in.q_u     = '0;
      prep_in.q_v     = '0;
      prep_in.neg_u   = in_data.num_u[ACC_W-1] ^ in_data.den[ACC_W-1];
      prep_in.neg_v   = in_data.num_v[ACC_W-1] ^ in_data.den[ACC_W-1];
      prep_in.ovf_u   = ACC_W'(un_u[ACC_W-1:INT_W]) >= ud;
      prep_in.ovf_v   = ACC_W'(un_v[ACC_W-1:INT_W]) >= ud;
      prep_in.dead    = in_data.outside || (in_data.den == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         st_ff[0] <= prep_in;
      end
   end

   // One quotient bit per stage; integer steps bring in the low dividend bits
   for (genvar k = 0; k < NStep; k++) begin : g_step
      logic             app_u, app_v;
      logic [ACC_W:0]   trial_u, trial_v, diff_u, diff_v;
      div_state_type    nxt;

      if (k < INT_W) begin : g_int
         assign app_u = st_ff[k].low_u[INT_W-1-k];
         assign app_v = st_ff[k].low_v[INT_W-1-k];
      end else begin : g_frac
         assign app_u = 1'b0;
         assign app_v = 1'b0;
      end

      always_comb begin
         nxt     = st_ff[k];
         trial_u = {st_ff[k].rem_u, app_u};
         trial_v = {st_ff[k].rem_v, app_v};
         diff_u  = trial_u - {1'b0, st_ff[k].dvs};
         diff_v  = trial_v - {1'b0, st_ff[k].dvs};
         if (trial_u >= {1'b0, st_ff[k].dvs}) begin
            nxt.rem_u = diff_u[ACC_W-1:0];
            nxt.q_u   = {st_ff[k].q_u[QUO_W-2:0], 1'b1};
         end else begin
            nxt.rem_u = trial_u[ACC_W-1:0];
            nxt.q_u   = {st_ff[k].q_u[QUO_W-2:0], 1'b0};
         end
         if (trial_v >= {1'b0, st_ff[k].dvs}) begin
            nxt.rem_v = diff_v[ACC_W-1:0];
            nxt.q_v   = {st_ff[k].q_v[QUO_W-2:0], 1'b1};
         end else begin
            nxt.rem_v = trial_v[ACC_W-1:0];
            nxt.q_v   = {st_ff[k].q_v[QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en[k+1]) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k+1]) begin
            st_ff[k+1] <= nxt;
         end
      end
   end

   // Round, clamp and flag
   always_comb begin
      fin_u = finish(st_ff[NStep].q_u, st_ff[NStep].neg_u, st_ff[NStep].ovf_u);
      fin_v = finish(st_ff[NStep].q_v, st_ff[NStep].neg_v, st_ff[NStep].ovf_v);
      if (st_ff[NStep].dead) begin
         rsp_in.src_u         = '0;
         rsp_in.src_v         = '0;
         rsp_in.coord_invalid = 1'b1;
      end else begin
         rsp_in.src_u         = fin_u[COORD_W-1:0];
         rsp_in.src_v         = fin_v[COORD_W-1:0];
         rsp_in.coord_invalid = fin_u[COORD_W] | fin_v[COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[NStep+1]) begin
         rsp_valid_ff <= v_ff[NStep];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NStep+1]) begin
         rsp_ff <= rsp_in;
      end
   end

   // The u remainder stays below the divisor once its quotient fits
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NStep] && !st_ff[NStep].ovf_u && st_ff[NStep].dvs != '0)
         |-> (st_ff[NStep].rem_u < st_ff[NStep].dvs))
      else $error("divider remainder out of range");

   // Overflowed quotient leaves flagged
   a_ovf_flag: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NStep] && en[NStep+1] && (st_ff[NStep].ovf_u || st_ff[NStep].ovf_v))
         |=> (rsp_valid_ff && rsp_ff.coord_invalid))
      else $error("overflow not flagged");

   // Dead item leaves as zero coordinates
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NStep] && en[NStep+1] && st_ff[NStep].dead)
         |=> (rsp_ff.src_u == '0 && rsp_ff.src_v == '0 && rsp_ff.coord_invalid))
      else $error("zero-denominator or outside item not cleared");

   // Input back-pressure only when the first stage holds an item
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> v_ff[0])
      else $error("input stalled with empty stage");

endmodule
